### src/morse_character_serializer_unit_macros.svh
// Assertion macros for the Morse character serializer checker.
// Depends on nothing; the including scope must provide clock and reset.
`ifndef MORSE_CHARACTER_SERIALIZER_UNIT_MACROS_SVH
`define MORSE_CHARACTER_SERIALIZER_UNIT_MACROS_SVH

// Implication checked only outside reset.
`define MCS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mcs assertion failed");

// Next-cycle implication checked at every edge, reset included.
`define MCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("mcs assertion failed");

`endif

### src/mcs_pkg.sv
// Shared types, constants and code tables for the Morse character serializer.
// Depends on nothing.
package mcs_pkg;

   localparam int unsigned CodeBits = 16;
   localparam int unsigned UnitBits = 5;

   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] FOLD_MASK    = 8'hDF;
   localparam logic [7:0] LETTER_FIRST = 8'h41;
   localparam logic [7:0] LETTER_LAST  = 8'h5A;

   localparam logic [UnitBits-1:0] LETTER_GAP_UNITS = 5'd3;
   localparam logic [UnitBits-1:0] WORD_GAP_UNITS   = 5'd7;

   typedef struct packed {
      logic [CodeBits-1:0] pattern;
      logic [UnitBits-1:0] units;
   } keying_type;

   // Keying pattern of a letter, MSB first; index 0 is A.
   function automatic logic [CodeBits-1:0] letter_pattern(input logic [4:0] idx);
      logic [CodeBits-1:0] p;
      unique case (idx)
         5'd0:    p = 16'hB800;
         5'd1:    p = 16'hEA80;
         5'd2:    p = 16'hEBA0;
         5'd3:    p = 16'hEA00;
         5'd4:    p = 16'h8000;
         5'd5:    p = 16'hAE80;
         5'd6:    p = 16'hEE80;
         5'd7:    p = 16'hAA00;
         5'd8:    p = 16'hA000;
         5'd9:    p = 16'hBBB8;
         5'd10:   p = 16'hEB80;
         5'd11:   p = 16'hBA80;
         5'd12:   p = 16'hEE00;
         5'd13:   p = 16'hE800;
         5'd14:   p = 16'hEEE0;
         5'd15:   p = 16'hBBA0;
         5'd16:   p = 16'hEEB8;
         5'd17:   p = 16'hBA00;
         5'd18:   p = 16'hA800;
         5'd19:   p = 16'hE000;
         5'd20:   p = 16'hAE00;
         5'd21:   p = 16'hAB80;
         5'd22:   p = 16'hBB80;
         5'd23:   p = 16'hEAE0;
         5'd24:   p = 16'hEBB8;
         5'd25:   p = 16'hEEA0;
         default: p = '0;
      endcase
      return p;
   endfunction

   // Pattern length up to and including its last on bit.
   function automatic logic [UnitBits-1:0] letter_length(input logic [4:0] idx);
      logic [UnitBits-1:0] n;
      unique case (idx) inside
         5'd4:                                     n = 5'd1;
         5'd8, 5'd19:                              n = 5'd3;
         5'd0, 5'd13, 5'd18:                       n = 5'd5;
         5'd3, 5'd7, 5'd12, 5'd17, 5'd20:          n = 5'd7;
         5'd1, 5'd5, 5'd6, 5'd10, 5'd11, 5'd21,
         5'd22:                                    n = 5'd9;
         5'd2, 5'd14, 5'd15, 5'd23, 5'd25:         n = 5'd11;
         5'd9, 5'd16, 5'd24:                       n = 5'd13;
         default:                                  n = '0;
      endcase
      return n;
   endfunction

   // Full keying sequence of one character: pattern and number of units.
   function automatic keying_type decode_char(input logic [7:0] ch);
      keying_type k;
      logic [7:0] up;
      logic [7:0] offset;
      up     = ch & FOLD_MASK;
      offset = up - LETTER_FIRST;
      k.pattern = '0;
      k.units   = '0;
      if (ch == SPACE_CODE) begin
         k.units = WORD_GAP_UNITS;
      end else if (up >= LETTER_FIRST && up <= LETTER_LAST) begin
         k.pattern = letter_pattern(offset[4:0]);
         k.units   = letter_length(offset[4:0]) + LETTER_GAP_UNITS;
      end
      return k;
   endfunction

endpackage

### src/mcs_req_if.sv
// Input channel of the Morse character serializer: one ASCII character per item.
// Depends on nothing.
interface mcs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

### src/mcs_rsp_if.sv
// Result channel of the Morse character serializer: one keying unit per item.
// Depends on nothing.
interface mcs_rsp_if;
   logic valid;
   logic ready;
   logic led_on;
   logic last_unit;

   modport source (output valid, output led_on, output last_unit, input ready);
   modport sink   (input valid, input led_on, input last_unit, output ready);
endinterface

### src/morse_character_serializer_unit.sv
// Top level of the Morse character serializer: holding register, decode, serializer.
// Depends on mcs_pkg, mcs_req_if and mcs_rsp_if.

// Each item on req carries one ASCII character; the block answers on rsp with
// that character's on/off keying, one dot time per item, and flags the final
// unit of the character with last_unit. Letters of either case send their Morse
// pattern followed by three off units, a space sends seven off units, and any
// other code sends nothing. A letter has 4 to 16 units and a space 7, and the
// serializer shifts out one unit per cycle while rsp stays ready; a character
// with no units passes the holding register and loads an empty count. An
// accepted character goes first into the holding register and then into the
// serializer registers, which offer its first unit. The next character waits
// in the holding register and enters the serializer in the same cycle as the
// previous character's last unit is taken, so units flow without gaps while
// rsp stays ready.
module morse_character_serializer_unit
   import mcs_pkg::*;
(
   input logic      clock,
   input logic      reset,
   mcs_req_if.sink  req,
   mcs_rsp_if.source rsp
);

   // Holding register for the next character.
   logic                hold_valid_ff, hold_valid_in;
   logic [7:0]          hold_char_ff, hold_char_in;

   // Serializer: remaining units and the pattern with the current unit in the MSB.
   logic [CodeBits-1:0] shift_ff, shift_in;
   logic [UnitBits-1:0] count_ff, count_in;

   keying_type          decoded;
   logic                req_fire;
   logic                rsp_fire;
   logic                load;

   assign decoded  = decode_char(hold_char_ff);
   assign rsp_fire = rsp.valid && rsp.ready;

   // The serializer takes a new character when it is empty or its last unit
   // leaves in this cycle.
   assign load      = (count_ff == '0) || (count_ff == UnitBits'(1) && rsp.ready);
   assign req.ready = !hold_valid_ff || load;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_char_in  = hold_char_ff;
      if (req_fire) begin
         hold_valid_in = 1'b1;
         hold_char_in  = req.char_code;
      end else if (load) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (load) begin
         // A character with no units simply loads an empty count.
         shift_in = hold_valid_ff ? decoded.pattern : '0;
         count_in = hold_valid_ff ? decoded.units : '0;
      end else if (rsp_fire) begin
         shift_in = {shift_ff[CodeBits-2:0], 1'b0};
         count_in = count_ff - UnitBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         count_ff      <= count_in;
      end
      hold_char_ff <= hold_char_in;
      shift_ff     <= shift_in;
   end

   assign rsp.valid     = (count_ff != '0);
   assign rsp.led_on    = shift_ff[CodeBits-1];
   assign rsp.last_unit = (count_ff == UnitBits'(1));

endmodule

### src/mcs_checker.sv
// Port-level checker for the Morse character serializer, with its bind.
// Depends on morse_character_serializer_unit_macros.svh and the top level.
`include "morse_character_serializer_unit_macros.svh"

module mcs_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_led_on,
   input logic rsp_last_unit
);

   // A unit offered but not taken stays offered.
   `MCS_ASSERT_IMP(rsp_valid_holds, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid)

   // A stalled unit keeps its level and its end flag.
   `MCS_ASSERT_IMP(rsp_payload_holds, $past(rsp_valid && !rsp_ready) && !$past(reset), $stable(rsp_led_on) && $stable(rsp_last_unit))

   // Every character ends on an off unit: a letter gap or a word gap.
   `MCS_ASSERT_IMP(last_unit_is_off, rsp_valid && rsp_last_unit, !rsp_led_on)

   // Nothing is offered and req is ready in the cycle after reset.
   `MCS_ASSERT_NEXT(idle_after_reset, reset, !rsp_valid && req_ready)

endmodule

bind morse_character_serializer_unit mcs_checker u_mcs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_led_on    (rsp.led_on),
   .rsp_last_unit (rsp.last_unit)
);

### tb/morse_character_serializer_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the Morse character serializer: watches both channels, predicts
// the keying units of every accepted character and compares them in order.
// Depends on mcs_req_if and mcs_rsp_if.
module morse_character_serializer_unit_checker (
   input  logic clock,
   input  logic reset,
   mcs_req_if   req,
   mcs_rsp_if   rsp,
   output int   mismatch_count,
   output int   units_outstanding
);

   typedef struct packed {
      logic led_on;
      logic last_unit;
   } keying_unit_type;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam logic [7:0] LETTER_A   = 8'h41;
   localparam logic [7:0] LETTER_Z   = 8'h5A;
   localparam int         CODE_WIDTH = 16;
   localparam int         LETTER_GAP = 3;
   localparam int         WORD_GAP   = 7;

   localparam logic [15:0] LETTER_CODES [26] = '{
      16'hB800, 16'hEA80, 16'hEBA0, 16'hEA00, 16'h8000, 16'hAE80, 16'hEE80,
      16'hAA00, 16'hA000, 16'hBBB8, 16'hEB80, 16'hBA80, 16'hEE00, 16'hE800,
      16'hEEE0, 16'hBBA0, 16'hEEB8, 16'hBA00, 16'hA800, 16'hE000, 16'hAE00,
      16'hAB80, 16'hBB80, 16'hEAE0, 16'hEBB8, 16'hEEA0
   };

   keying_unit_type expected_units_q[$];

   initial begin
      mismatch_count    = 0;
      units_outstanding = 0;
   end

   // Appends the keying units that one character produces.
   task automatic queue_keying_units(input logic [7:0] ch);
      logic [7:0]  folded;
      logic [15:0] code;
      int          code_len;
      int          total;
      keying_unit_type unit;
      folded = ch & ~CASE_BIT;
      if (ch == SPACE_CHAR) begin
         for (int k = 0; k < WORD_GAP; k++) begin
            unit.led_on    = 1'b0;
            unit.last_unit = (k == WORD_GAP - 1);
            expected_units_q.push_back(unit);
         end
      end else if (folded >= LETTER_A && folded <= LETTER_Z) begin
         code     = LETTER_CODES[int'(folded - LETTER_A)];
         code_len = CODE_WIDTH;
         // The code runs up to and including its lowest set bit.
         while (code_len > 0 && !code[CODE_WIDTH - code_len]) begin
            code_len--;
         end
         total = code_len + LETTER_GAP;
         for (int k = 0; k < total; k++) begin
            unit.led_on    = (k < code_len) ? code[CODE_WIDTH - 1 - k] : 1'b0;
            unit.last_unit = (k == total - 1);
            expected_units_q.push_back(unit);
         end
      end
   endtask

   always @(posedge clock) begin
      keying_unit_type want;
      if (!reset) begin
         if (req.valid && req.ready) begin
            queue_keying_units(req.char_code);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_units_q.size() == 0) begin
               $display("%0t: unexpected unit, expected none, got led_on=%b last_unit=%b",
                        $time, rsp.led_on, rsp.last_unit);
               mismatch_count++;
            end else begin
               want = expected_units_q.pop_front();
               if (rsp.led_on !== want.led_on) begin
                  $display("%0t: led_on mismatch, expected %b, got %b",
                           $time, want.led_on, rsp.led_on);
                  mismatch_count++;
               end
               if (rsp.last_unit !== want.last_unit) begin
                  $display("%0t: last_unit mismatch, expected %b, got %b",
                           $time, want.last_unit, rsp.last_unit);
                  mismatch_count++;
               end
            end
         end
      end
      units_outstanding <= expected_units_q.size();
   end

endmodule

### tb/morse_character_serializer_unit_tb.sv
`timescale 1ns / 1ps
// Top of the Morse character serializer testbench: clock, reset, character
// stimulus, receiver stalls, watchdog and verdict.
// Depends on mcs_req_if, mcs_rsp_if, the serializer and its checker.
module morse_character_serializer_unit_tb;

   localparam int RANDOM_CHARS   = 350;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam logic [7:0] LETTER_A   = 8'h41;

   // Directed characters: both cases at both ends of the alphabet, the
   // shortest and longest codes, back-to-back spaces, the neighbors of the
   // letter ranges, the all-zero and all-one codes and high codes whose folded
   // value is not a letter.
   localparam logic [7:0] DIRECTED_CHARS [21] = '{
      8'h41, 8'h61, 8'h5A, 8'h7A, 8'h45, 8'h4A, 8'h71, 8'h59, 8'h20, 8'h20,
      8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC1, 8'hE1, 8'h7F, 8'h4F,
      8'h54
   };

   // Receiver ready pattern used during the patterned stall phase.
   localparam logic [15:0] STALL_PATTERN = 16'b1011_0010_1110_0111;

   logic clock = 1'b0;
   logic reset;

   mcs_req_if req_ch ();
   mcs_rsp_if rsp_ch ();

   int mismatch_count;
   int units_outstanding;
   int burst_left;
   int idle_cycles;
   logic [7:0] stall_phase;

   morse_character_serializer_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   morse_character_serializer_unit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req               (req_ch),
      .rsp               (rsp_ch),
      .mismatch_count    (mismatch_count),
      .units_outstanding (units_outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver cycles through four stall phases: always ready, a fixed ready
   // pattern, light random stalls and heavy random stalls. Characters last 4 to
   // 16 units, so each phase lands on many different positions inside a
   // character.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_phase  <= '0;
      end else begin
         stall_phase <= stall_phase + 8'd1;
         case (stall_phase[7:6])
            2'd0: begin
               rsp_ch.ready <= 1'b1;
            end
            2'd1: begin
               rsp_ch.ready <= STALL_PATTERN[stall_phase[3:0]];
            end
            2'd2: begin
               rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_ch.ready <= ($urandom_range(0, 2) == 0);
            end
         endcase
      end
   end

   // The watchdog restarts on every accepted item on either channel; a long
   // stretch with no progress at all means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one character and returns at the edge where it is accepted. The
   // sender works in bursts: when a burst is used up, valid drops for a random
   // gap before the next burst starts. Within a burst valid stays high and only
   // the character changes, so valid never gets two updates in one step.
   task automatic send_char(input logic [7:0] ch);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= ch;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      burst_left--;
   endtask

   // Holds the sender off until every predicted unit has been taken.
   task automatic wait_units_drained();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do begin
         @(posedge clock);
      end while (units_outstanding != 0);
   endtask

   // Mostly letters of either case, with spaces and arbitrary bytes mixed in.
   function automatic logic [7:0] random_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return (LETTER_A + 8'($urandom_range(0, 25))) |
                ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
      end else if (pick < 72) begin
         return SPACE_CHAR;
      end else begin
         return 8'($urandom_range(0, 255));
      end
   endfunction

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      rsp_ch.ready     = 1'b0;
      burst_left       = 0;
      idle_cycles      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_CHARS[i]) begin
         send_char(DIRECTED_CHARS[i]);
      end
      wait_units_drained();

      // Halfway through, the sender pauses once more until the block has
      // emptied, so a fresh character also meets an idle serializer.
      for (int i = 0; i < RANDOM_CHARS; i++) begin
         if (i == RANDOM_CHARS / 2) begin
            wait_units_drained();
         end
         send_char(random_char());
      end

      wait_units_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/mcs_pkg.sv
src/mcs_req_if.sv
src/mcs_rsp_if.sv
src/morse_character_serializer_unit.sv
src/mcs_checker.sv
tb/morse_character_serializer_unit_checker.sv
tb/morse_character_serializer_unit_tb.sv
